FILE: rtl/core/fader_hysteresis_motor_drive_assert.svh
// Assertion macros shared by the fader drive RTL.
`ifndef FADER_HYSTERESIS_MOTOR_DRIVE_ASSERT_SVH
`define FADER_HYSTERESIS_MOTOR_DRIVE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FHMD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FHMD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fhmd_pkg.sv
// Types and constants for the motorized fader tracker and drive.
`timescale 1ns / 1ps
`default_nettype none
package fhmd_pkg;

	localparam int POS_W   = 10;
	localparam int TOUCH_W = 16;
	localparam int FID_W   = 2;
	localparam int CODE_W  = 2;
	localparam int PWM_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Request kinds.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_DRIVE  = 1'b1;

	// Register groups, selected by the top bit of the register index.
	localparam logic REG_GRP_HYST  = 1'b0;
	localparam logic REG_GRP_TOUCH = 1'b1;

	// Movement classes.
	localparam logic [CODE_W-1:0] MOVE_SAME = 2'd0;
	localparam logic [CODE_W-1:0] MOVE_UP   = 2'd1;
	localparam logic [CODE_W-1:0] MOVE_DOWN = 2'd2;

	// Motor directions.
	localparam logic [CODE_W-1:0] DIR_HALT = 2'd0;
	localparam logic [CODE_W-1:0] DIR_UP   = 2'd1;
	localparam logic [CODE_W-1:0] DIR_DOWN = 2'd2;

	// Drive gaps and duties.
	localparam logic signed [POS_W:0] FAR_GAP  = 11'sd150;
	localparam logic signed [POS_W:0] NEAR_GAP = 11'sd5;
	localparam logic [PWM_W-1:0] PWM_FAR  = 8'd167;
	localparam logic [PWM_W-1:0] PWM_NEAR = 8'd100;

	// One request as held in the evaluation stage.
	typedef struct packed {
		logic               req_type;
		logic [FID_W-1:0]   fader;
		logic [POS_W-1:0]   wiper;
		logic [TOUCH_W-1:0] touch;
		logic [POS_W-1:0]   target;
		logic               served;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [FID_W-1:0]  fader_id;
		logic [CODE_W-1:0] move_class;
		logic [POS_W-1:0]  position;
		logic              touched;
		logic [CODE_W-1:0] motor_dir;
		logic [PWM_W-1:0]  motor_pwm;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/core/fader_hysteresis_motor_drive.sv
// Top level of the motorized fader hysteresis tracker and motor drive.
//
//   Channel   Direction  Handshake               Content
//   in        into       in_valid / in_stall     request: kind, fader, wiper, touch, target
//   out       out of     out_valid / out_stall   result: fader, class, position, touch, drive
//   cfg       into       cfg_valid / cfg_ready   register index and write data
//
// One request per clock is sustained while the output is not stalled; a result
// passes from the evaluation stage, which covers the registered read of the
// position RAM, into the output register, where the receiver can take it.
// Reset clears the per-fader valid bits, so every position reads as zero
// at once; no clearing pass is needed. A stalled result holds in the output
// register while one more request is taken into the evaluation stage.
`timescale 1ns / 1ps
`default_nettype none
`include "fader_hysteresis_motor_drive_assert.svh"
module fader_hysteresis_motor_drive
	import fhmd_pkg::*;
#(
	parameter int NUM_FADERS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  req_type,
	input  wire logic [FID_W-1:0]      fader_index,
	input  wire logic [POS_W-1:0]      wiper_sample,
	input  wire logic [TOUCH_W-1:0]    touch_sample,
	input  wire logic [POS_W-1:0]      target_position,
	// Result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [FID_W-1:0]      fader_id,
	output logic      [CODE_W-1:0]     move_class,
	output logic      [POS_W-1:0]      position,
	output logic                       touched,
	output logic      [CODE_W-1:0]     motor_dir,
	output logic      [PWM_W-1:0]      motor_pwm,
	// Configuration channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1;
	localparam logic [FID_W:0] NF = (FID_W + 1)'(NUM_FADERS);

	logic [POS_W-1:0]   hyst_q   [NUM_FADERS];
	logic [TOUCH_W-1:0] thresh_q [NUM_FADERS];
	logic [NUM_FADERS-1:0] ent_vld_q;

	logic               in_accept;
	logic               out_free;
	logic               s1_adv;
	logic               valid_s1;
	req_t               req_s1;
	logic [AW-1:0]      addr_s1;

	logic               ram_we;
	logic [POS_W-1:0]   ram_rdata;
	logic               wr_valid_q;
	logic [AW-1:0]      wr_addr_q;
	logic [POS_W-1:0]   wr_data_q;

	logic               fwd;
	logic               ent_vld;
	logic [POS_W-1:0]   hyst_sel;
	logic [TOUCH_W-1:0] thresh_sel;
	logic [POS_W-1:0]   cur;
	logic [POS_W-1:0]   new_pos;
	res_t               res;

	logic               out_valid_q;
	res_t               res_q;

	// Configuration registers; every transaction is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FADERS; i++) begin
				hyst_q[i]   <= '0;
				thresh_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_FADERS; i++) begin
				if (cfg_index[FID_W-1:0] == FID_W'(i)) begin
					case (cfg_index[CFG_IDX_W-1])
						REG_GRP_HYST:  hyst_q[i]   <= cfg_data[POS_W-1:0];
						REG_GRP_TOUCH: thresh_q[i] <= cfg_data;
						default: ;
					endcase
				end
			end
		end
	end

	// Handshake: the evaluation stage moves on whenever the output register frees up.
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_adv    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	// Evaluation stage register, filled as the position RAM is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || out_free) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1.req_type <= req_type;
			req_s1.fader    <= fader_index;
			req_s1.wiper    <= wiper_sample;
			req_s1.touch    <= touch_sample;
			req_s1.target   <= target_position;
			req_s1.served   <= ({1'b0, fader_index} < NF);
		end
	end

	assign addr_s1 = req_s1.fader[AW-1:0];

	// Tracked positions live in the RAM.
	assign ram_we = s1_adv && req_s1.served && (req_s1.req_type == REQ_SAMPLE);

	fhmd_ram #(
		.WIDTH (POS_W),
		.DEPTH (NUM_FADERS)
	) u_pos_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_pos),
		.re    (in_accept),
		.raddr (fader_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Last write, kept to forward over a read that collided with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (ram_we) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= new_pos;
		end
	end

	// Per-entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_FADERS; i++) begin
				if (ram_we && (addr_s1 == AW'(i))) begin
					ent_vld_q[i] <= 1'b1;
				end
			end
		end
	end

	// Per-fader selection of valid bit and settings.
	always_comb begin
		ent_vld    = 1'b0;
		hyst_sel   = '0;
		thresh_sel = '0;
		for (int i = 0; i < NUM_FADERS; i++) begin
			if (addr_s1 == AW'(i)) begin
				ent_vld    = ent_vld_q[i];
				hyst_sel   = hyst_q[i];
				thresh_sel = thresh_q[i];
			end
		end
	end

	// Current position with forwarding from the previous write.
	assign fwd = wr_valid_q && (wr_addr_q == addr_s1);
	assign cur = fwd ? wr_data_q : (ent_vld ? ram_rdata : '0);

	fhmd_eval u_eval (
		.req     (req_s1),
		.cur     (cur),
		.hyst    (hyst_sel),
		.thresh  (thresh_sel),
		.new_pos (new_pos),
		.res     (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign fader_id   = res_q.fader_id;
	assign move_class = res_q.move_class;
	assign position   = res_q.position;
	assign touched    = res_q.touched;
	assign motor_dir  = res_q.motor_dir;
	assign motor_pwm  = res_q.motor_pwm;

	// Checks on the pipeline and the result encoding.
	`FHMD_ASSERT_IMP(a_we_on_advance, ram_we, s1_adv && valid_s1, "RAM written without an advancing item")
	`FHMD_ASSERT_NXT(a_s1_holds, valid_s1 && !out_free, valid_s1 && $stable(addr_s1), "held item lost or changed")
	`FHMD_ASSERT_IMP(a_pwm_dir, out_valid_q, (motor_pwm == '0) == (motor_dir == DIR_HALT), "duty and direction disagree")
	`FHMD_ASSERT_IMP(a_move_no_drive, out_valid_q && (move_class != MOVE_SAME), motor_pwm == '0, "sample result carries drive")

endmodule
`default_nettype wire

FILE: rtl/core/fhmd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fhmd_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read returns the old data on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fhmd_eval.sv
// Hysteresis, touch and drive decisions for one request.
`timescale 1ns / 1ps
`default_nettype none
module fhmd_eval
	import fhmd_pkg::*;
(
	input  wire req_t               req,
	input  wire logic [POS_W-1:0]   cur,
	input  wire logic [POS_W-1:0]   hyst,
	input  wire logic [TOUCH_W-1:0] thresh,
	output logic      [POS_W-1:0]   new_pos,
	output res_t                    res
);

	logic [POS_W:0]        wiper_plus_h;
	logic [POS_W:0]        cur_plus_h;
	logic signed [POS_W:0] gap;

	// Band edges and the signed distance to the target.
	assign wiper_plus_h = {1'b0, req.wiper} + {1'b0, hyst};
	assign cur_plus_h   = {1'b0, cur} + {1'b0, hyst};
	assign gap          = $signed({1'b0, req.target}) - $signed({1'b0, cur});

	// Result selection; an unserved fader gives zeros apart from its index.
	always_comb begin
		res          = '0;
		res.fader_id = req.fader;
		new_pos      = cur;
		if (req.served) begin
			if (req.req_type == REQ_SAMPLE) begin
				if ({1'b0, cur} > wiper_plus_h) begin
					new_pos        = req.wiper;
					res.move_class = MOVE_DOWN;
				end else if ({1'b0, req.wiper} > cur_plus_h) begin
					new_pos        = req.wiper;
					res.move_class = MOVE_UP;
				end
				res.touched = (req.touch > thresh);
			end else begin
				if (gap > FAR_GAP) begin
					res.motor_dir = DIR_UP;
					res.motor_pwm = PWM_FAR;
				end else if (gap > NEAR_GAP) begin
					res.motor_dir = DIR_UP;
					res.motor_pwm = PWM_NEAR;
				end else if (gap < -FAR_GAP) begin
					res.motor_dir = DIR_DOWN;
					res.motor_pwm = PWM_FAR;
				end else if (gap < -NEAR_GAP) begin
					res.motor_dir = DIR_DOWN;
					res.motor_pwm = PWM_NEAR;
				end
			end
			res.position = new_pos;
		end
	end

endmodule
`default_nettype wire
